/* rtl/core/fds_pkg.sv */
// Shared definitions for the Forth data-stack unit: opcodes, status codes,
// stack effect decode and the controller/datapath interface structs.
// No dependencies.
`default_nettype none
package fds_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int DATA_W = 64;

	typedef enum logic [4:0] {
		CMD_PUSH    = 5'd0,
		CMD_DROP    = 5'd1,
		CMD_DUP     = 5'd2,
		CMD_SWAP    = 5'd3,
		CMD_OVER    = 5'd4,
		CMD_TUCK    = 5'd5,
		CMD_NIP     = 5'd6,
		CMD_TWOSWAP = 5'd7,
		CMD_TWOOVER = 5'd8,
		CMD_ADD     = 5'd9,
		CMD_SUB     = 5'd10,
		CMD_MUL     = 5'd11,
		CMD_DIV     = 5'd12,
		CMD_MOD     = 5'd13,
		CMD_LT      = 5'd14,
		CMD_GT      = 5'd15,
		CMD_EQ      = 5'd16,
		CMD_NE      = 5'd17,
		CMD_CELLS   = 5'd18,
		CMD_PEEK    = 5'd19
	} cmd_t;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_UNDER = 2'd1;
	localparam status_t ST_OVER  = 2'd2;
	localparam status_t ST_DIVZ  = 2'd3;

	// Number of entries consumed by a primitive.
	function automatic logic [2:0] stack_need(input logic [4:0] c);
		logic [2:0] n;
		n = 3'd0;
		case (c)
			CMD_PUSH, CMD_PEEK: n = 3'd0;
			CMD_DROP, CMD_DUP, CMD_CELLS: n = 3'd1;
			CMD_TWOSWAP, CMD_TWOOVER: n = 3'd4;
			default: begin
				if (c >= CMD_SWAP && c <= CMD_NE)
					n = 3'd2;
			end
		endcase
		return n;
	endfunction

	// Number of entries produced by a primitive.
	function automatic logic [2:0] stack_give(input logic [4:0] c);
		logic [2:0] g;
		g = 3'd0;
		case (c)
			CMD_DROP: g = 3'd0;
			CMD_DUP, CMD_SWAP: g = 3'd2;
			CMD_OVER, CMD_TUCK: g = 3'd3;
			CMD_TWOSWAP: g = 3'd4;
			CMD_TWOOVER: g = 3'd6;
			default: begin
				if (c <= CMD_CELLS)
					g = 3'd1;
			end
		endcase
		return g;
	endfunction

	typedef struct packed {
		logic    latch;
		logic    cap;
		logic    exec;
		logic    mul_en;
		logic    div_init;
		logic    div_step;
		logic    fin;
		logic    wr_en;
		logic    commit;
		logic    top_cap;
		logic    set_status;
		status_t status;
		logic    done;
		logic [2:0] k;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       is_op;
		logic       under;
		logic       over;
		logic       divz;
		logic       is_mul;
		logic       is_div;
		logic [2:0] need;
		logic [2:0] give;
		logic       end_empty;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/fds_ctrl.sv */
// Sequencer for the Forth data-stack unit: walks each primitive through
// operand reads, execution, result writes and the report.
// Depends on fds_pkg.
`default_nettype none
module fds_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  fds_pkg::dp_stat_t     stat,
	output fds_pkg::ctrl_cmd_t    ctl
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_CHK  = 13'b0000000000010,
		S_RD   = 13'b0000000000100,
		S_CAP  = 13'b0000000001000,
		S_EXEC = 13'b0000000010000,
		S_MUL  = 13'b0000000100000,
		S_DIV  = 13'b0000001000000,
		S_FIN  = 13'b0000010000000,
		S_WR   = 13'b0000100000000,
		S_CMT  = 13'b0001000000000,
		S_TRD  = 13'b0010000000000,
		S_TCAP = 13'b0100000000000,
		S_RESP = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic [6:0] cnt_q, cnt_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ctl = '0;
		ctl.k = cnt_q[2:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cnt_d = '0;
				ctl.set_status = 1'b1;
				if (!stat.is_op) begin
					ctl.status = fds_pkg::ST_OK;
					state_d = S_RESP;
				end else if (stat.under) begin
					ctl.status = fds_pkg::ST_UNDER;
					state_d = S_RESP;
				end else if (stat.over) begin
					ctl.status = fds_pkg::ST_OVER;
					state_d = S_RESP;
				end else if (stat.need == 3'd0) begin
					ctl.set_status = 1'b0;
					state_d = S_EXEC;
				end else begin
					ctl.set_status = 1'b0;
					state_d = S_RD;
				end
			end
			S_RD: state_d = S_CAP;
			S_CAP: begin
				ctl.cap = 1'b1;
				if (cnt_q[2:0] == stat.need - 3'd1) begin
					state_d = S_EXEC;
				end else begin
					cnt_d = cnt_q + 7'd1;
					state_d = S_RD;
				end
			end
			S_EXEC: begin
				cnt_d = '0;
				if (stat.divz) begin
					ctl.set_status = 1'b1;
					ctl.status = fds_pkg::ST_DIVZ;
					state_d = S_RESP;
				end else if (stat.is_mul) begin
					state_d = S_MUL;
				end else if (stat.is_div) begin
					ctl.div_init = 1'b1;
					state_d = S_DIV;
				end else begin
					ctl.exec = 1'b1;
					state_d = (stat.give == 3'd0) ? S_CMT : S_WR;
				end
			end
			S_MUL: begin
				ctl.mul_en = 1'b1;
				cnt_d = cnt_q + 7'd1;
				if (cnt_q[1:0] == 2'd3)
					state_d = S_FIN;
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				cnt_d = cnt_q + 7'd1;
				if (cnt_q == 7'd63)
					state_d = S_FIN;
			end
			S_FIN: begin
				ctl.fin = 1'b1;
				cnt_d = '0;
				state_d = S_WR;
			end
			S_WR: begin
				ctl.wr_en = 1'b1;
				if (cnt_q[2:0] == stat.give - 3'd1) begin
					state_d = S_CMT;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_CMT: begin
				ctl.commit = 1'b1;
				ctl.set_status = 1'b1;
				ctl.status = fds_pkg::ST_OK;
				cnt_d = '0;
				if (stat.give == 3'd0 && !stat.end_empty)
					state_d = S_TRD;
				else
					state_d = S_RESP;
			end
			S_TRD: state_d = S_TCAP;
			S_TCAP: begin
				ctl.top_cap = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				ctl.done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/fds_dp.sv */
// Datapath for the Forth data-stack unit: stack memory, operand and result
// registers, shared multiplier, bit-serial divider and report registers.
// Depends on fds_pkg.
`default_nettype none
module fds_dp #(
	parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [4:0]            cmd,
	input  wire  [63:0]           push_value,
	input  fds_pkg::ctrl_cmd_t    ctl,
	output fds_pkg::dp_stat_t     stat,
	output logic [63:0]           top_value,
	output logic [6:0]            stack_depth,
	output logic [1:0]            status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(STACK_DEPTH);

	logic [63:0] mem [STACK_DEPTH];
	logic [63:0] rdata_q;
	logic [4:0]  cmd_q;
	logic [63:0] lit_q;
	logic [CW-1:0] count_q;
	logic [63:0] tos_q;
	logic [63:0] opnd_q [4];
	logic [63:0] res_q [6];
	logic [63:0] res_d [6];
	fds_pkg::status_t status_q;
	logic [63:0] prod_q, acc_q, prod_d;
	logic [63:0] quo_q, rem_q;
	logic [64:0] shifted;
	logic        ge;
	logic [2:0]  need, give;
	logic [CW:0] after;
	logic [CW-1:0] raddr_full, waddr_full;
	logic [CW+6:0] depth_ext;
	logic [63:0] a, b, c, d;

	assign a = opnd_q[0];
	assign b = opnd_q[1];
	assign c = opnd_q[2];
	assign d = opnd_q[3];

	assign need = fds_pkg::stack_need(cmd_q);
	assign give = fds_pkg::stack_give(cmd_q);
	assign after = {1'b0, count_q} - (CW + 1)'(need) + (CW + 1)'(give);

	always_comb begin
		stat = '0;
		stat.is_op = (cmd_q <= fds_pkg::CMD_CELLS);
		stat.need = need;
		stat.give = give;
		stat.under = ({1'b0, count_q} < (CW + 1)'(need));
		stat.over = (after > DEPTH_W);
		stat.is_mul = (cmd_q == fds_pkg::CMD_MUL);
		stat.is_div = (cmd_q == fds_pkg::CMD_DIV) || (cmd_q == fds_pkg::CMD_MOD);
		stat.divz = stat.is_div && (a == 64'd0);
		stat.end_empty = (after == '0);
	end

	assign raddr_full = count_q - CW'(1) - CW'(ctl.k);
	assign waddr_full = count_q - CW'(need) + CW'(ctl.k);

	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			mem[waddr_full[AW-1:0]] <= res_q[ctl.k];
		rdata_q <= mem[raddr_full[AW-1:0]];
	end

	always_comb begin
		for (int i = 0; i < 6; i++)
			res_d[i] = 64'd0;
		case (cmd_q)
			fds_pkg::CMD_PUSH: res_d[0] = lit_q;
			fds_pkg::CMD_DUP: begin
				res_d[0] = a;
				res_d[1] = a;
			end
			fds_pkg::CMD_SWAP: begin
				res_d[0] = a;
				res_d[1] = b;
			end
			fds_pkg::CMD_OVER: begin
				res_d[0] = b;
				res_d[1] = a;
				res_d[2] = b;
			end
			fds_pkg::CMD_TUCK: begin
				res_d[0] = a;
				res_d[1] = b;
				res_d[2] = a;
			end
			fds_pkg::CMD_NIP: res_d[0] = a;
			fds_pkg::CMD_TWOSWAP: begin
				res_d[0] = b;
				res_d[1] = a;
				res_d[2] = d;
				res_d[3] = c;
			end
			fds_pkg::CMD_TWOOVER: begin
				res_d[0] = d;
				res_d[1] = c;
				res_d[2] = b;
				res_d[3] = a;
				res_d[4] = d;
				res_d[5] = c;
			end
			fds_pkg::CMD_ADD: res_d[0] = b + a;
			fds_pkg::CMD_SUB: res_d[0] = b - a;
			fds_pkg::CMD_LT: res_d[0] = 64'(b < a);
			fds_pkg::CMD_GT: res_d[0] = 64'(b > a);
			fds_pkg::CMD_EQ: res_d[0] = 64'(b == a);
			fds_pkg::CMD_NE: res_d[0] = 64'(b != a);
			fds_pkg::CMD_CELLS: res_d[0] = {a[60:0], 3'b000};
			default: res_d[0] = 64'd0;
		endcase
	end

	// Low 64 bits of the product from three 32x32 partial products.
	always_comb begin
		case (ctl.k[1:0])
			2'd0: prod_d = a[31:0] * b[31:0];
			2'd1: prod_d = a[31:0] * b[63:32];
			default: prod_d = a[63:32] * b[31:0];
		endcase
	end

	assign shifted = {rem_q, quo_q[63]};
	assign ge = (shifted >= {1'b0, a});

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd;
			lit_q <= push_value;
		end
		if (ctl.cap)
			opnd_q[ctl.k[1:0]] <= rdata_q;
		if (ctl.exec) begin
			for (int i = 0; i < 6; i++)
				res_q[i] <= res_d[i];
		end
		if (ctl.mul_en) begin
			prod_q <= prod_d;
			if (ctl.k[1:0] == 2'd1)
				acc_q <= prod_q;
			else if (ctl.k[1:0] != 2'd0)
				acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
		end
		if (ctl.div_init) begin
			quo_q <= b;
			rem_q <= 64'd0;
		end else if (ctl.div_step) begin
			rem_q <= ge ? 64'(shifted - {1'b0, a}) : shifted[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
		if (ctl.fin) begin
			if (cmd_q == fds_pkg::CMD_MUL)
				res_q[0] <= acc_q;
			else if (cmd_q == fds_pkg::CMD_DIV)
				res_q[0] <= quo_q;
			else
				res_q[0] <= rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tos_q <= 64'd0;
			status_q <= fds_pkg::ST_OK;
		end else begin
			if (ctl.set_status)
				status_q <= ctl.status;
			if (ctl.commit) begin
				count_q <= after[CW-1:0];
				if (give == 3'd0)
					tos_q <= 64'd0;
				else
					tos_q <= res_q[give - 3'd1];
			end
			if (ctl.top_cap)
				tos_q <= rdata_q;
		end
	end

	assign depth_ext = {7'd0, count_q};
	assign top_value = tos_q;
	assign stack_depth = depth_ext[6:0];
	assign status = status_q;

endmodule
`default_nettype wire

/* rtl/core/forth_data_stack_alu.sv */
// Top level of the Forth data-stack unit: joins the sequencer and datapath.
// Depends on fds_pkg, fds_ctrl and fds_dp.
//
// One primitive is transferred when start is high while busy is low; busy
// stays high until the result has been shown. The result is on top_value,
// stack_depth and status for exactly one cycle with done high, and the
// receiver cannot stall it. A primitive that is rejected for underflow,
// overflow or an unused code goes straight from the check to the report;
// otherwise its need entries are read through the single registered memory
// read port and its give entries are written through its write port.
// Multiply also forms three 32x32 partial products, and divide and modulo
// run the one-bit-per-cycle divider. Drop also reads the new top of stack
// unless it leaves the stack empty.
`default_nettype none
module forth_data_stack_alu #(
	parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [4:0]  cmd,
	input  wire  [63:0] push_value,
	output logic        done,
	output logic [63:0] top_value,
	output logic [6:0]  stack_depth,
	output logic [1:0]  status
);

	fds_pkg::ctrl_cmd_t ctl;
	fds_pkg::dp_stat_t  stat;

	fds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	fds_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.push_value  (push_value),
		.ctl         (ctl),
		.stat        (stat),
		.top_value   (top_value),
		.stack_depth (stack_depth),
		.status      (status)
	);

	assign done = ctl.done;

endmodule
`default_nettype wire
